/* rtl/core/lrc_pkg.sv */
package lrc_pkg;

	// field widths fixed by the item format
	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int CAP_W = 7;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	// outcome of one pass through the tag store
	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} tag_res_t;

endpackage

/* rtl/core/lrc_tags.sv */
module lrc_tags import lrc_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           go,
	input  op_t                            op,
	input  logic [KEY_W-1:0]               key,
	input  logic [CAP_W-1:0]               capacity,
	output tag_res_t                       res,
	output logic [$clog2(MAX_ENTRIES)-1:0] slot_idx
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [KEY_W-1:0]       key_q [MAX_ENTRIES];
	logic [IDX_W-1:0]       rank_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]       live_q;

	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] free_oh;
	logic [MAX_ENTRIES-1:0] valid_inc;
	logic [MAX_ENTRIES-1:0] lru_oh;
	logic [MAX_ENTRIES-1:0] slot_oh;
	logic [MAX_ENTRIES-1:0] valid_mid;
	logic [MAX_ENTRIES-1:0] victim_oh;
	logic [MAX_ENTRIES-1:0] evict_oh;
	logic [MAX_ENTRIES-1:0] valid_nxt;
	logic [IDX_W-1:0]       rank_mid [MAX_ENTRIES];
	logic [IDX_W-1:0]       rank_nxt [MAX_ENTRIES];
	logic [IDX_W-1:0]       hit_rank;
	logic [CNT_W-1:0]       live_dec;
	logic [CNT_W-1:0]       live_mid;
	logic [CNT_W-1:0]       live_mid_dec;
	logic [CNT_W-1:0]       live_nxt;
	logic [CMP_W-1:0]       cap_ext;
	logic [CMP_W-1:0]       cap_eff;
	logic                   hit;
	logic                   full;
	logic                   ins;
	logic                   ins_new;
	logic                   ev_full;
	logic                   ev_cap;
	logic                   update;
	logic [KEY_W-1:0]       ev_key;

	// parallel key compare
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key);
		end
	end

	assign hit      = |match;
	assign ins      = (op == OP_INSERT);
	assign ins_new  = ins && !hit;
	assign full     = (live_q == CNT_W'(MAX_ENTRIES));
	assign live_dec = live_q - CNT_W'(1);

	// lowest free slot and current least recent entry
	assign valid_inc = valid_q + MAX_ENTRIES'(1);
	assign free_oh   = ~valid_q & valid_inc;

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			lru_oh[i] = valid_q[i] && (rank_q[i] == live_dec[IDX_W-1:0]);
		end
	end

	assign ev_full = ins_new && full;
	assign slot_oh = hit ? match : (full ? lru_oh : free_oh);

	// rank of the hit entry
	always_comb begin
		hit_rank = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match[i]) begin
				hit_rank = hit_rank | rank_q[i];
			end
		end
	end

	// ranks after touch or insert, before capacity eviction
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot_oh[i]) begin
				rank_mid[i] = '0;
			end else if (valid_q[i] && (ins_new || (rank_q[i] < hit_rank))) begin
				rank_mid[i] = rank_q[i] + IDX_W'(1);
			end else begin
				rank_mid[i] = rank_q[i];
			end
		end
	end

	assign valid_mid    = ins_new ? (valid_q | slot_oh) : valid_q;
	assign live_mid     = (ins_new && !full) ? (live_q + CNT_W'(1)) : live_q;
	assign live_mid_dec = live_mid - CNT_W'(1);

	// effective capacity, clamped to one and to the store size
	assign cap_ext = CMP_W'(capacity);
	always_comb begin
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// capacity eviction after an insert
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			victim_oh[i] = valid_mid[i] && (rank_mid[i] == live_mid_dec[IDX_W-1:0]);
		end
	end

	assign ev_cap   = ins && !ev_full && (CMP_W'(live_mid) > cap_eff);
	assign evict_oh = ev_full ? lru_oh : (ev_cap ? victim_oh : '0);

	always_comb begin
		ev_key = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (evict_oh[i]) begin
				ev_key = ev_key | key_q[i];
			end
		end
	end

	// final state after this item
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ev_cap && victim_oh[i]) begin
				valid_nxt[i] = 1'b0;
				rank_nxt[i]  = '0;
			end else begin
				valid_nxt[i] = valid_mid[i];
				rank_nxt[i]  = rank_mid[i];
			end
		end
	end

	assign live_nxt = ev_cap ? live_mid_dec : live_mid;
	assign update   = go && (hit || ins);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (update) begin
			valid_q <= valid_nxt;
			live_q  <= live_nxt;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= rank_nxt[i];
			end
		end
	end

	// key store, written into the chosen slot on a new key
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (go && ins_new && slot_oh[i]) begin
				key_q[i] <= key;
			end
		end
	end

	// slot index for the value memories
	always_comb begin
		slot_idx = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (slot_oh[i]) begin
				slot_idx = slot_idx | IDX_W'(i);
			end
		end
	end

	assign res.hit         = hit;
	assign res.evicted     = ev_full || ev_cap;
	assign res.evicted_key = ev_key;

endmodule

/* rtl/core/lru_result_cache_unit.sv */
// path: an item passes the input register, then the result register
// throughput: one lookup or insert per cycle while the receiver does not stall; the tag
// compare and rank update over the whole store are combinational between the two registers
// reset: store empty (all entries invalid, ranks and live count zero), capacity 64,
// no clearing pass, ready for items right after reset
module lru_result_cache_unit import lrc_pkg::*; #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] barrier_bits,
	input  logic [VAL_W-1:0] diff_bits,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             hit,
	output logic [VAL_W-1:0] found_barrier_bits,
	output logic [VAL_W-1:0] found_diff_bits,
	output logic             evicted,
	output logic [KEY_W-1:0] evicted_key
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	logic [CAP_W-1:0] capacity_q;

	logic             valid_s1;
	op_t              op_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] barrier_s1;
	logic [VAL_W-1:0] diff_s1;

	logic             valid_s2;
	logic             hit_s2;
	logic             lookup_hit_s2;
	logic             evicted_s2;
	logic [KEY_W-1:0] evicted_key_s2;
	logic [VAL_W-1:0] rd_barrier_s2;
	logic [VAL_W-1:0] rd_diff_s2;

	logic [VAL_W-1:0] mem_barrier [MAX_ENTRIES];
	logic [VAL_W-1:0] mem_diff [MAX_ENTRIES];

	logic             load;
	logic             adv;
	logic             wr_en;
	tag_res_t         tag_res;
	logic [IDX_W-1:0] slot_idx;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// handshake: stage 1 moves on when the result register is free or being taken
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= load || (valid_s1 && !adv);
			valid_s2 <= adv || (valid_s2 && out_stall);
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (load) begin
			op_s1      <= op_t'(operation);
			key_s1     <= key;
			barrier_s1 <= barrier_bits;
			diff_s1    <= diff_bits;
		end
	end

	// tag store with recency ranks
	lrc_tags #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_tags (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (adv),
		.op       (op_s1),
		.key      (key_s1),
		.capacity (capacity_q),
		.res      (tag_res),
		.slot_idx (slot_idx)
	);

	// value memories: write on insert, registered read for the result
	assign wr_en = adv && (op_s1 == OP_INSERT);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_barrier[slot_idx] <= barrier_s1;
			mem_diff[slot_idx]    <= diff_s1;
		end
		if (adv) begin
			rd_barrier_s2 <= mem_barrier[slot_idx];
			rd_diff_s2    <= mem_diff[slot_idx];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s2         <= tag_res.hit;
			lookup_hit_s2  <= tag_res.hit && (op_s1 == OP_LOOKUP);
			evicted_s2     <= tag_res.evicted;
			evicted_key_s2 <= tag_res.evicted_key;
		end
	end

	assign out_valid          = valid_s2;
	assign hit                = hit_s2;
	assign found_barrier_bits = lookup_hit_s2 ? rd_barrier_s2 : '0;
	assign found_diff_bits    = lookup_hit_s2 ? rd_diff_s2 : '0;
	assign evicted            = evicted_s2;
	assign evicted_key        = evicted_key_s2;

endmodule

/* bench/tb_lru_result_cache_unit.sv */
`timescale 1ns / 1ps

module tb_lru_result_cache_unit import lrc_pkg::*;;

	localparam int ENTRIES      = 64;
	localparam int POOL_SIZE    = 96;
	localparam int RANDOM_ITEMS = 1830;
	localparam int CYCLE_LIMIT  = 400000;

	// one result transfer as the cache should produce it
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] found_barrier;
		logic [VAL_W-1:0] found_diff;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} access_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             operation = OP_LOOKUP;
	logic [KEY_W-1:0] key = '0;
	logic [VAL_W-1:0] barrier_bits = '0;
	logic [VAL_W-1:0] diff_bits = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             hit;
	logic [VAL_W-1:0] found_barrier_bits;
	logic [VAL_W-1:0] found_diff_bits;
	logic             evicted;
	logic [KEY_W-1:0] evicted_key;

	// shadow copy of the cache contents
	logic [KEY_W-1:0] slot_key [ENTRIES];
	logic [VAL_W-1:0] slot_barrier [ENTRIES];
	logic [VAL_W-1:0] slot_diff [ENTRIES];
	logic             slot_valid [ENTRIES];
	int               slot_rank [ENTRIES];
	int               live_entries = 0;
	logic [CAP_W-1:0] capacity_setting = CAPACITY_RESET;

	access_result_t   access_results_q [$];
	access_result_t   last_result;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               error_count = 0;
	int               cycle_count = 0;
	int               burst_left = 0;
	int               items_sent = 0;
	int               stall_mode = 0;
	int               stall_span = 0;

	lru_result_cache_unit dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.operation          (operation),
		.key                (key),
		.barrier_bits       (barrier_bits),
		.diff_bits          (diff_bits),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.hit                (hit),
		.found_barrier_bits (found_barrier_bits),
		.found_diff_bits    (found_diff_bits),
		.evicted            (evicted),
		.evicted_key        (evicted_key)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** lru_result_cache_unit: FAILED **");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// move one entry to the front of the recency order
	function automatic void make_recent(int s);
		int r;
		r = slot_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	// drop the least recent entry, give back its slot and key
	function automatic int evict_oldest(output logic [KEY_W-1:0] k);
		int s;
		int oldest;
		s = -1;
		oldest = 0;
		k = '0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && (s < 0 || slot_rank[i] > oldest)) begin
				s = i;
				oldest = slot_rank[i];
			end
		if (s >= 0) begin
			k = slot_key[s];
			slot_valid[s] = 1'b0;
			slot_rank[s] = 0;
			live_entries--;
		end
		return s;
	endfunction

	// apply one lookup or insert to the shadow cache and return its outcome
	function automatic access_result_t predict_access(op_t op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] b, logic [VAL_W-1:0] d);
		access_result_t res;
		int s;
		int eff_cap;
		logic [KEY_W-1:0] out_key;
		res = '0;
		out_key = '0;
		eff_cap = capacity_setting;
		if (eff_cap < 1) eff_cap = 1;
		if (eff_cap > ENTRIES) eff_cap = ENTRIES;
		s = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (s < 0 && slot_valid[i] && slot_key[i] == k) s = i;
		res.hit = (s >= 0);
		if (op == OP_LOOKUP) begin
			if (s >= 0) begin
				res.found_barrier = slot_barrier[s];
				res.found_diff = slot_diff[s];
				make_recent(s);
			end
		end else begin
			if (s >= 0) begin
				slot_barrier[s] = b;
				slot_diff[s] = d;
				make_recent(s);
			end else begin
				for (int i = 0; i < ENTRIES; i++)
					if (s < 0 && !slot_valid[i]) s = i;
				// store full: reuse the least recent slot
				if (s < 0) begin
					s = evict_oldest(out_key);
					res.evicted = 1'b1;
				end
				for (int i = 0; i < ENTRIES; i++)
					if (slot_valid[i]) slot_rank[i]++;
				slot_key[s] = k;
				slot_barrier[s] = b;
				slot_diff[s] = d;
				slot_valid[s] = 1'b1;
				slot_rank[s] = 0;
				live_entries++;
			end
			// at most one eviction per insert when over capacity
			if (!res.evicted && live_entries > eff_cap)
				if (evict_oldest(out_key) >= 0) res.evicted = 1'b1;
		end
		if (res.evicted) res.evicted_key = out_key;
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s at cycle %0d: got %h expected %h", field, cycle_count, got, want);
		error_count++;
	endtask

	// result checking against the oldest expectation
	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (access_results_q.size() == 0) begin
				report_mismatch("unexpected result transfer", {63'd0, hit}, 64'd0);
			end else begin
				want = access_results_q.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", {63'd0, hit}, {63'd0, want.hit});
				if (found_barrier_bits !== want.found_barrier)
					report_mismatch("found_barrier_bits", found_barrier_bits, want.found_barrier);
				if (found_diff_bits !== want.found_diff)
					report_mismatch("found_diff_bits", found_diff_bits, want.found_diff);
				if (evicted !== want.evicted)
					report_mismatch("evicted", {63'd0, evicted}, {63'd0, want.evicted});
				if (evicted_key !== want.evicted_key)
					report_mismatch("evicted_key", evicted_key, want.evicted_key);
			end
		end
	end

	// receiver stall pattern, mode changes every so often
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(20, 150);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ((cycle_count % 5) < 2);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// send one item, in bursts with random gaps between them
	task automatic send_access(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] b,
			logic [VAL_W-1:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		barrier_bits <= b;
		diff_bits <= d;
		do @(posedge clk); while (in_stall);
		last_result = predict_access(op, k, b, d);
		access_results_q.push_back(last_result);
		items_sent++;
	endtask

	// wait until every expected result transfer has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (access_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_setting = value;
	endtask

	// field extremes, hit, miss and refresh at reset capacity
	task automatic test_lookup_insert_basics();
		send_access(OP_LOOKUP, '0, rand64(), rand64());
		send_access(OP_INSERT, '0, '1, '1);
		send_access(OP_LOOKUP, '0, '0, '0);
		send_access(OP_INSERT, '1, '0, '0);
		send_access(OP_LOOKUP, '1, '1, '1);
		send_access(OP_INSERT, '0, rand64(), rand64());
		send_access(OP_LOOKUP, '0, '0, '0);
		send_access(OP_LOOKUP, rand64(), rand64(), rand64());
	endtask

	// capacity dropped below the live count
	task automatic test_capacity_lowered();
		for (int i = 0; i < 5; i++)
			send_access(OP_INSERT, key_pool[i], rand64(), rand64());
		set_capacity(7'd2);
		send_access(OP_LOOKUP, key_pool[0], '0, '0);
		send_access(OP_INSERT, key_pool[1], rand64(), rand64());
		send_access(OP_INSERT, key_pool[5], rand64(), rand64());
		send_access(OP_LOOKUP, key_pool[4], '0, '0);
	endtask

	// capacity one, then zero which acts as one
	task automatic test_tiny_capacity();
		set_capacity(7'd1);
		send_access(OP_INSERT, key_pool[6], rand64(), rand64());
		send_access(OP_INSERT, key_pool[7], rand64(), rand64());
		send_access(OP_LOOKUP, key_pool[6], '0, '0);
		send_access(OP_LOOKUP, key_pool[7], '0, '0);
		set_capacity(7'd0);
		send_access(OP_INSERT, key_pool[8], rand64(), rand64());
		send_access(OP_LOOKUP, key_pool[8], '0, '0);
	endtask

	// random traffic over several capacity settings, mostly lookup then fill on miss
	task automatic test_random_phases();
		logic [CAP_W-1:0] caps [12];
		int phase_target;
		int phase_start;
		int pool_used;
		int eff_cap;
		int r;
		logic [KEY_W-1:0] k;
		caps = '{7'd127, 7'd64, 7'd5, 7'd100, 7'd1, 7'd48, 7'd0, 7'd2, 7'd65, 7'd17, 7'd127,
			7'd0};
		caps[11] = $urandom_range(0, 127);
		phase_target = RANDOM_ITEMS / 12;
		for (int p = 0; p < 12; p++) begin
			set_capacity(caps[p]);
			eff_cap = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES ? ENTRIES : caps[p]);
			pool_used = eff_cap * 3 / 2 + 4;
			if (pool_used > POOL_SIZE) pool_used = POOL_SIZE;
			phase_start = items_sent;
			while (items_sent - phase_start < phase_target) begin
				r = $urandom_range(0, 99);
				k = key_pool[$urandom_range(0, pool_used - 1)];
				if (r < 70) begin
					send_access(OP_LOOKUP, k, rand64(), rand64());
					if (!last_result.hit && $urandom_range(0, 9) < 8)
						send_access(OP_INSERT, k, rand64(), rand64());
				end else if (r < 92) begin
					send_access(OP_INSERT, k, rand64(), rand64());
				end else begin
					send_access($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, rand64(),
						rand64(), rand64());
				end
			end
		end
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			slot_key[i] = '0;
			slot_barrier[i] = '0;
			slot_diff[i] = '0;
			slot_valid[i] = 1'b0;
			slot_rank[i] = 0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = rand64();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lookup_insert_basics();
		test_capacity_lowered();
		test_tiny_capacity();
		test_random_phases();
		drain_results();
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("** lru_result_cache_unit: PASSED **");
		end else begin
			$display("** lru_result_cache_unit: FAILED **");
		end
		$finish;
	end

endmodule
